>>> hdl/edfts_pkg.sv
// ----------------------------------------------------------------------------
// edfts_pkg
// Shared types and constants for the earliest-deadline-first tick scheduler.
// ----------------------------------------------------------------------------
package edfts_pkg;

    // Task set and field widths.
    localparam int NUM_TASKS   = 4;
    localparam int TASK_W      = 2;
    localparam int VAL_W       = 16;
    localparam int CNT_W       = 32;
    localparam int MISS_W      = 4;

    // Configuration port geometry: register i sits at byte address 4*i.
    localparam int NUM_REGS    = 2 * NUM_TASKS;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    // Stream widths, padded to whole bytes.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 80;

    // Register kind, taken from the lowest bit of the register index.
    localparam logic REG_EXEC   = 1'b0;
    localparam logic REG_PERIOD = 1'b1;

    typedef logic [VAL_W-1:0]  val_t;
    typedef logic [TASK_W-1:0] task_idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // Configuration of all tasks, as seen by the scheduling core.
    typedef struct packed {
        val_t [NUM_TASKS-1:0] exec_time;
        val_t [NUM_TASKS-1:0] period;
    } task_cfg_t;

    // One result item; the last member sits in the lowest bits.
    typedef struct packed {
        cnt_t              busy_ticks;
        logic [MISS_W-1:0] missed_mask;
        task_idx_t         preempted_task;
        logic              preempted_valid;
        task_idx_t         running_task;
        logic              running_valid;
        cnt_t              tick_number;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

>>> hdl/edfts_regs.sv
// ----------------------------------------------------------------------------
// edfts_regs
// Configuration register file: execution time and period of each task,
// written and read over the APB-style port.
// ----------------------------------------------------------------------------
module edfts_regs
    import edfts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output task_cfg_t         cfg
);

    val_t      exec_time_reg [NUM_TASKS];
    val_t      period_reg    [NUM_TASKS];
    logic      wr_en;
    logic      reg_kind;
    task_idx_t reg_task;
    val_t      rd_val;

    // The register index is the word address; its low bit picks the kind.
    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign reg_kind = paddr[2];
    assign reg_task = paddr[ADDR_W-1:3];

    // Register writes; reset gives a disabled task with a period of one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                exec_time_reg[i] <= '0;
                period_reg[i]    <= val_t'(1);
            end
        end
        else if (wr_en)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                if (reg_task == TASK_W'(i))
                begin
                    if (reg_kind == REG_PERIOD)
                    begin
                        period_reg[i] <= pwdata[VAL_W-1:0];
                    end
                    else
                    begin
                        exec_time_reg[i] <= pwdata[VAL_W-1:0];
                    end
                end
            end
        end
    end

    // Read-back of the addressed register.
    always_comb
    begin
        if (reg_kind == REG_EXEC)
        begin
            rd_val = exec_time_reg[reg_task];
        end
        else
        begin
            rd_val = period_reg[reg_task];
        end
    end

    assign prdata = DATA_W'(rd_val);

    // Present the configuration to the scheduling core.
    always_comb
    begin
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            cfg.exec_time[i] = exec_time_reg[i];
            cfg.period[i]    = period_reg[i];
        end
    end

endmodule

>>> hdl/edfts_core.sv
// ----------------------------------------------------------------------------
// edfts_core
// Task state and the single-pass scheduling decision: release, earliest
// deadline selection, preemption check and counters for one tick.
// ----------------------------------------------------------------------------
module edfts_core
    import edfts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  logic      restart,
    input  task_cfg_t cfg,
    output result_t   res
);

    val_t      work_left_reg [NUM_TASKS];
    val_t      work_left_next [NUM_TASKS];
    val_t      ttr_reg [NUM_TASKS];
    val_t      ttr_next [NUM_TASKS];
    logic      prior_valid_reg;
    logic      prior_valid_next;
    task_idx_t prior_task_reg;
    task_idx_t prior_task_next;
    cnt_t      tick_count_reg;
    cnt_t      tick_count_next;
    cnt_t      busy_count_reg;
    cnt_t      busy_count_next;

    val_t      work_rel [NUM_TASKS];
    val_t      ttr_rel [NUM_TASKS];
    logic [MISS_W-1:0] missed;
    logic      run_valid;
    task_idx_t run;
    logic      pre_valid;
    task_idx_t pre;
    logic      base_prior_valid;
    task_idx_t base_prior;
    cnt_t      base_tick;
    cnt_t      base_busy;

    // Release stage: a restart makes every task look freshly reset, so all
    // tasks release on this tick.
    always_comb
    begin
        missed = '0;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            val_t base_work;
            val_t base_ttr;
            base_work = restart ? '0 : work_left_reg[i];
            base_ttr  = restart ? '0 : ttr_reg[i];
            if (base_ttr == '0)
            begin
                missed[i]   = (base_work != '0);
                work_rel[i] = cfg.exec_time[i];
                ttr_rel[i]  = (cfg.period[i] == '0) ? val_t'(1) : cfg.period[i];
            end
            else
            begin
                work_rel[i] = base_work;
                ttr_rel[i]  = base_ttr;
            end
        end
    end

    // Earliest deadline among tasks with work left; ties keep the lower index.
    always_comb
    begin
        run_valid = 1'b0;
        run       = '0;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            if (work_rel[i] != '0 && (!run_valid || ttr_rel[i] < ttr_rel[run]))
            begin
                run_valid = 1'b1;
                run       = TASK_W'(i);
            end
        end
    end

    // Preemption check, next task state and counters.
    always_comb
    begin
        base_prior_valid = restart ? 1'b0 : prior_valid_reg;
        base_prior       = restart ? '0 : prior_task_reg;
        base_tick        = restart ? '0 : tick_count_reg;
        base_busy        = restart ? '0 : busy_count_reg;

        for (int i = 0; i < NUM_TASKS; i++)
        begin
            work_left_next[i] = work_rel[i]
                              - {{(VAL_W-1){1'b0}}, (run_valid && run == TASK_W'(i))};
            ttr_next[i]       = ttr_rel[i] - val_t'(1);
        end

        pre_valid = 1'b0;
        pre       = '0;
        if (run_valid && base_prior_valid && base_prior != run
            && work_rel[base_prior] != '0)
        begin
            pre_valid = 1'b1;
            pre       = base_prior;
        end

        prior_valid_next = run_valid;
        prior_task_next  = run_valid ? run : '0;
        tick_count_next  = base_tick + cnt_t'(1);
        busy_count_next  = base_busy + {{(CNT_W-1){1'b0}}, run_valid};
    end

    // State update once per tick that moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                work_left_reg[i] <= '0;
                ttr_reg[i]       <= '0;
            end
            prior_valid_reg <= 1'b0;
            prior_task_reg  <= '0;
            tick_count_reg  <= '0;
            busy_count_reg  <= '0;
        end
        else if (step)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                work_left_reg[i] <= work_left_next[i];
                ttr_reg[i]       <= ttr_next[i];
            end
            prior_valid_reg <= prior_valid_next;
            prior_task_reg  <= prior_task_next;
            tick_count_reg  <= tick_count_next;
            busy_count_reg  <= busy_count_next;
        end
    end

    // Result of this tick.
    always_comb
    begin
        res.tick_number     = tick_count_next;
        res.running_valid   = run_valid;
        res.running_task    = run;
        res.preempted_valid = pre_valid;
        res.preempted_task  = pre;
        res.missed_mask     = missed;
        res.busy_ticks      = busy_count_next;
    end

endmodule

>>> hdl/edf_tick_scheduler_core.sv
// ----------------------------------------------------------------------------
// edf_tick_scheduler_core
// Path: an input transfer is held in the input register, then its result in the result register on the master side.
// Throughput: 1 tick per cycle while the master side accepts results; the decision is one pass through edfts_core.
// Reset (rst_n low, async): pipeline empty, task state and counters cleared.
// ----------------------------------------------------------------------------
module edf_tick_scheduler_core
    import edfts_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Slave side
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // [0] restart, [7:1] zero
    // Master side
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [31:0] tick_number, [32] running_valid, [34:33] running_task,
    // [35] preempted_valid, [37:36] preempted_task, [41:38] missed_mask,
    // [73:42] busy_ticks, [79:74] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // Configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready
);

    task_cfg_t cfg;
    result_t   res;
    logic      in_valid_reg;
    logic      in_valid_next;
    logic      in_restart_reg;
    logic      out_valid_reg;
    logic      out_valid_next;
    result_t   out_data_reg;
    logic      advance;
    logic      step;
    logic      in_xfer;

    edfts_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    edfts_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .restart (in_restart_reg),
        .cfg     (cfg),
        .res     (res)
    );

    // Handshake: the input register moves on whenever the result register
    // is empty or its transfer completes.
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next  = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = step ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_restart_reg <= s_tdata[0];
        end
        if (step)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

`ifndef SYNTHESIS
    // An empty result register never holds off the slave side.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("slave side stalled with an empty result register");

    // A tick that leaves the input register shows up as a result next cycle.
    a_step_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> m_tvalid)
        else $error("scheduled tick did not reach the result register");

    // A preemption comes only with a running task different from the displaced one.
    a_preempt_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && out_data_reg.preempted_valid |->
            out_data_reg.running_valid
            && (out_data_reg.preempted_task != out_data_reg.running_task))
        else $error("preemption reported without a different running task");
`endif

endmodule
